FILE: rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
`default_nettype none
package bra_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int RUN_W          = 11;
    localparam int MAX_ADDR_BYTES = 128;
    localparam logic [7:0] CFG_RESET = 8'd128;

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_SCAN  = 2'd1;
    localparam logic [1:0] FN_TEST  = 2'd2;
    localparam logic [1:0] FN_SET   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] run_length;
        logic [9:0]  bit_index;
        logic        bit_value;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [9:0] run_start;
        logic       bit_state;
    } rsp_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       pos;
        logic [RUN_W-1:0] run_next;
    } step_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_BIT_RD,
        ST_BIT_WAIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/bra_map_ram.sv
// Bitmap byte store: one write port, one registered read port.
`default_nettype none
module bra_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire logic [7:0]     wdata,
    input  wire logic           re,
    input  wire logic [AW-1:0]  raddr,
    output logic      [7:0]     rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bra_run_step.sv
// Run counter unit: advances the free-bit run over one map byte.
`default_nettype none
module bra_run_step (
    input  wire logic [7:0]                 data,
    input  wire logic [bra_pkg::RUN_W-1:0]  run_in,
    input  wire logic [bra_pkg::RUN_W-1:0]  len,
    output bra_pkg::step_t                  step
);

    logic [bra_pkg::RUN_W-1:0] cur;
    logic                      hit;
    logic [2:0]                pos;

    always_comb
    begin
        cur = run_in;
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < bra_pkg::BYTE_BITS; j++)
        begin
            cur = data[j] ? '0 : cur + 1'b1;
            if (!hit && cur == len)
            begin
                hit = 1'b1;
                pos = 3'(j);
            end
        end
        step.hit      = hit;
        step.pos      = pos;
        step.run_next = cur;
    end

endmodule
`default_nettype wire

FILE: rtl/bitmap_run_allocator_top.sv
// Bitmap run allocator: sequencer, config register and result register.
// Clear: zeroes every byte of the store, DEPTH = min(MAP_BYTES, 128).
// Scan: one map byte per cycle through the run unit, over the bytes in use.
// Test and set: a read on the single RAM read port; set then writes the byte back (read-modify-write).
// One request at a time; the result register frees the input once loaded.
// After reset the store is zeroed by a sweep over all DEPTH bytes; requests stall meanwhile.
`default_nettype none
module bitmap_run_allocator_top #(
    parameter int MAP_BYTES = 128
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bra_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bra_pkg::rsp_t      rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);

    localparam int DEPTH = (MAP_BYTES < bra_pkg::MAX_ADDR_BYTES) ?
                           MAP_BYTES : bra_pkg::MAX_ADDR_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bra_pkg::state_t           state_reg, state_next;
    bra_pkg::req_t             req_reg, req_next;
    bra_pkg::rsp_t             res_reg, res_next;
    bra_pkg::rsp_t             rsp_reg, rsp_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic [7:0]                bytes_reg;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             proc_reg, proc_next;
    logic                      dvld_reg, dvld_next;
    logic [bra_pkg::RUN_W-1:0] run_reg, run_next;

    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_waddr, mem_raddr;
    logic [7:0]                mem_wdata, mem_rdata;
    bra_pkg::step_t            step;

    logic [CW-1:0]             nbytes;
    logic                      clr_last, proc_last, in_range, out_free;
    logic [bra_pkg::RUN_W-1:0] start_full;

    assign nbytes    = (bytes_reg < 8'(DEPTH)) ? CW'(bytes_reg) : CW'(DEPTH);
    assign clr_last  = (ptr_reg == CW'(DEPTH - 1));
    assign proc_last = (proc_reg == CW'(nbytes - 1'b1));
    assign in_range  = (8'(req_reg.bit_index[9:3]) < 8'(nbytes));
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign start_full = bra_pkg::RUN_W'({proc_reg[AW-1:0], step.pos}) + 1'b1
                        - req_reg.run_length;

    assign req_stall = (state_reg != bra_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    bra_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bra_run_step u_step (
        .data   (mem_rdata),
        .run_in (run_reg),
        .len    (req_reg.run_length),
        .step   (step)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bra_pkg::ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = bra_pkg::ST_IDLE;
                end
            end
            bra_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.func)
                        bra_pkg::FN_CLEAR: state_next = bra_pkg::ST_CLEAR;
                        bra_pkg::FN_SCAN:
                        begin
                            if (req.run_length == '0 || nbytes == '0)
                            begin
                                state_next = bra_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = bra_pkg::ST_SCAN;
                            end
                        end
                        default: state_next = bra_pkg::ST_BIT_RD;
                    endcase
                end
            end
            bra_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = bra_pkg::ST_DONE;
                end
            end
            bra_pkg::ST_SCAN:
            begin
                if (dvld_reg && (step.hit || proc_last))
                begin
                    state_next = bra_pkg::ST_DONE;
                end
            end
            bra_pkg::ST_BIT_RD:
            begin
                state_next = in_range ? bra_pkg::ST_BIT_WAIT : bra_pkg::ST_DONE;
            end
            bra_pkg::ST_BIT_WAIT: state_next = bra_pkg::ST_DONE;
            bra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bra_pkg::ST_IDLE;
                end
            end
            default: state_next = bra_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        ptr_next       = ptr_reg;
        proc_next      = proc_reg;
        dvld_next      = 1'b0;
        run_next       = run_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AW-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg[AW-1:0];
        case (state_reg)
            bra_pkg::ST_INIT, bra_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            bra_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    res_next  = '0;
                    ptr_next  = '0;
                    proc_next = '0;
                    run_next  = '0;
                end
            end
            bra_pkg::ST_SCAN:
            begin
                mem_re    = (ptr_reg < nbytes);
                dvld_next = mem_re;
                if (mem_re)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (dvld_reg)
                begin
                    run_next  = step.run_next;
                    proc_next = proc_reg + 1'b1;
                    if (step.hit)
                    begin
                        res_next.found     = 1'b1;
                        res_next.run_start = start_full[9:0];
                    end
                end
            end
            bra_pkg::ST_BIT_RD:
            begin
                mem_re    = in_range;
                mem_raddr = req_reg.bit_index[3 +: AW];
            end
            bra_pkg::ST_BIT_WAIT:
            begin
                if (req_reg.func == bra_pkg::FN_TEST)
                begin
                    res_next.bit_state = mem_rdata[req_reg.bit_index[2:0]];
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = req_reg.bit_index[3 +: AW];
                    mem_wdata = mem_rdata;
                    mem_wdata[req_reg.bit_index[2:0]] = req_reg.bit_value;
                end
            end
            bra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bra_pkg::ST_INIT;
            rsp_valid_reg <= 1'b0;
            bytes_reg     <= bra_pkg::CFG_RESET;
            ptr_reg       <= '0;
            dvld_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            ptr_reg       <= ptr_next;
            dvld_reg      <= dvld_next;
            if (cfg_valid && cfg_ready)
            begin
                bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
        proc_reg <= proc_next;
        run_reg  <= run_next;
    end

endmodule
`default_nettype wire

FILE: rtl/bra_checker.sv
// Port-level checks for the bitmap run allocator, bound to the top level.
`default_nettype none
module bra_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire bra_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire bra_pkg::rsp_t rsp
);

    // one request in flight: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("input accepted on back-to-back cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.found && rsp.bit_state))
    else $error("scan and test fields both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.run_start == '0)
    else $error("run start nonzero without a found run");

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire
